>>> hw/rtl/trm_pkg.sv
// ============================================================================
// trm_pkg
// Shared constants for the trusted mark rectangle rasterizer: register
// indexes, reset values, result status codes and mark geometry limits.
// ============================================================================
package trm_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int COLOR_W    = 24;
    localparam int DIM_W      = 13;
    localparam int COORD_W    = 12;
    localparam int SIDE_W     = 5;
    localparam int STATUS_W   = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [SIDE_W-1:0]    side_t;

    localparam cfg_idx_t CFG_DISPLAY_WIDTH    = 3'd0;
    localparam cfg_idx_t CFG_DISPLAY_HEIGHT   = 3'd1;
    localparam cfg_idx_t CFG_FOUNDATION_COLOR = 3'd2;
    localparam cfg_idx_t CFG_CHROME_COLOR     = 3'd3;
    localparam cfg_idx_t CFG_SECURE_COLOR     = 3'd4;

    localparam logic [DIM_W-1:0]   RST_DISPLAY_WIDTH    = 13'd1920;
    localparam logic [DIM_W-1:0]   RST_DISPLAY_HEIGHT   = 13'd1080;
    localparam logic [COLOR_W-1:0] RST_FOUNDATION_COLOR = 24'h000000;
    localparam logic [COLOR_W-1:0] RST_CHROME_COLOR     = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] RST_SECURE_COLOR     = 24'h00FF00;

    localparam status_t STATUS_FILL      = 2'd0;
    localparam status_t STATUS_BAD_ENTRY = 2'd1;
    localparam status_t STATUS_BAD_THEME = 2'd2;

    localparam logic [1:0] PRES_CHROME = 2'd0;
    localparam logic [1:0] PRES_SECURE = 2'd1;

    localparam side_t SIDE_SECURE   = 5'd18;
    localparam side_t SIDE_CHROME   = 5'd14;
    localparam side_t FT_THICK_MIN  = 5'd10;
    localparam side_t CT_THICK_MIN  = 5'd7;
    localparam side_t FT_MID_MIN    = 5'd5;
    localparam side_t SEAM_MIN_SIDE = 5'd4;

endpackage

>>> hw/rtl/trusted_mark_rect_rasterizer.sv
// ============================================================================
// trusted_mark_rect_rasterizer
// Validates one overlay entry and emits the fill rectangles of its trusted
// mark, or a single status result for a bad entry or theme.
// ============================================================================
// An entry is taken only while the block is idle, so a new request waits until
// the last result of the previous entry is loaded. A rejected entry runs two
// checks and a status step; a chrome mark runs two checks, three setup steps
// and four bars; a secure mark with seams adds the X0 and SEAMY setup steps and
// a foundation pass and a core pass of seam columns. Bound checks and setup
// addresses pass through one shared 14-bit adder, one operation a cycle, and
// results leave one a cycle through a single output register unless out_stall holds it.
module trusted_mark_rect_rasterizer
    import trm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  cfg_idx_t             cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [31:0]          surface_id,
    input  logic [1:0]           presentation,
    input  logic signed [12:0]   bounds_x,
    input  logic signed [12:0]   bounds_y,
    input  logic [12:0]          bounds_width,
    input  logic [12:0]          bounds_height,
    input  logic [31:0]          frame_seq,

    output logic                 out_valid,
    input  logic                 out_stall,
    output status_t              status,
    output logic [COORD_W-1:0]   rect_x,
    output logic [COORD_W-1:0]   rect_y,
    output side_t                rect_w,
    output side_t                rect_h,
    output logic [COLOR_W-1:0]   rect_color,
    output logic                 last
);

    localparam logic [14:0] MaxDimLim = 15'(MAX_DIM);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHKX,
        S_CHKY,
        S_STAT,
        S_LEFT,
        S_FTX,
        S_CTX,
        S_X0,
        S_SEAMY,
        S_BAR,
        S_SEAM
    } state_t;

    state_t               state_reg;

    logic [DIM_W-1:0]     disp_w_reg;
    logic [DIM_W-1:0]     disp_h_reg;
    logic [COLOR_W-1:0]   found_color_reg;
    logic [COLOR_W-1:0]   chrome_color_reg;
    logic [COLOR_W-1:0]   secure_color_reg;

    logic [COORD_W-1:0]   bx_reg;
    logic [COORD_W-1:0]   by_reg;
    logic [DIM_W-1:0]     bw_reg;
    logic [DIM_W-1:0]     bh_reg;
    logic                 secure_reg;
    logic                 bad_reg;
    status_t              stat_code_reg;

    logic [13:0]          right_reg;
    logic [COORD_W-1:0]   left_reg;
    logic [COORD_W-1:0]   xf_reg;
    logic [COORD_W-1:0]   xc_reg;
    logic [COORD_W-1:0]   x0_reg;
    logic [COORD_W-1:0]   y0_reg;
    logic [COORD_W-1:0]   x_cur_reg;
    logic [COORD_W-1:0]   y_cur_reg;
    logic [3:0]           d_reg;
    logic                 pass_reg;
    logic [1:0]           bar_idx_reg;
    side_t                len_reg;
    logic [1:0]           ft_reg;
    logic [1:0]           ct_reg;

    logic                 out_valid_reg;
    status_t              status_reg;
    logic [COORD_W-1:0]   rect_x_reg;
    logic [COORD_W-1:0]   rect_y_reg;
    side_t                rect_w_reg;
    side_t                rect_h_reg;
    logic [COLOR_W-1:0]   rect_color_reg;
    logic                 last_reg;

    logic [13:0]          add_a;
    logic [13:0]          add_b;
    logic                 add_cin;
    logic [13:0]          sum;

    logic                 accept;
    logic                 ld;
    logic                 emit;
    logic                 theme_bad;
    logic                 disp_ok;
    logic                 has_seam;
    logic [COLOR_W-1:0]   core_color;
    logic [DIM_W-1:0]     avail;
    side_t                side_lim;
    side_t                len_new;
    side_t                len_m1;
    side_t                seam_off;
    side_t                len_m3;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign ld       = !out_valid_reg || !out_stall;
    assign emit     = ld && ((state_reg == S_STAT) || (state_reg == S_BAR)
                          || (state_reg == S_SEAM));

    assign theme_bad = (found_color_reg == chrome_color_reg)
                    || (found_color_reg == secure_color_reg)
                    || (chrome_color_reg == secure_color_reg);
    assign disp_ok   = (disp_w_reg != '0) && ({2'b00, disp_w_reg} <= MaxDimLim)
                    && (disp_h_reg != '0) && ({2'b00, disp_h_reg} <= MaxDimLim);

    assign avail    = (bw_reg < bh_reg) ? bw_reg : bh_reg;
    assign side_lim = secure_reg ? SIDE_SECURE : SIDE_CHROME;
    assign len_new  = (avail < {8'd0, side_lim}) ? avail[SIDE_W-1:0] : side_lim;
    assign len_m1   = len_reg - 5'd1;
    assign len_m3   = len_reg - 5'd3;
    assign seam_off = {3'b000, ft_reg} + {1'b0, len_m3[SIDE_W-1:1]};
    assign has_seam = secure_reg && (len_reg >= SEAM_MIN_SIDE);
    assign core_color = secure_reg ? secure_color_reg : chrome_color_reg;

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            S_CHKX:
            begin
                add_a = {2'b00, bx_reg};
                add_b = {1'b0, bw_reg};
            end
            S_CHKY:
            begin
                add_a = {2'b00, by_reg};
                add_b = {1'b0, bh_reg};
            end
            S_LEFT:
            begin
                add_a   = right_reg;
                add_b   = ~{9'd0, len_reg};
                add_cin = 1'b1;
            end
            S_FTX:
            begin
                add_a   = right_reg;
                add_b   = ~{12'd0, ft_reg};
                add_cin = 1'b1;
            end
            S_CTX:
            begin
                add_a   = right_reg;
                add_b   = ~{12'd0, ct_reg};
                add_cin = 1'b1;
            end
            S_X0:
            begin
                add_a   = right_reg;
                add_b   = ~{9'd0, len_m1};
                add_cin = 1'b1;
            end
            S_SEAMY:
            begin
                add_a = {2'b00, by_reg};
                add_b = {9'd0, seam_off};
            end
            default:
            begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
    end

    assign sum = add_a + add_b + {13'd0, add_cin};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            disp_w_reg       <= RST_DISPLAY_WIDTH;
            disp_h_reg       <= RST_DISPLAY_HEIGHT;
            found_color_reg  <= RST_FOUNDATION_COLOR;
            chrome_color_reg <= RST_CHROME_COLOR;
            secure_color_reg <= RST_SECURE_COLOR;
            bx_reg           <= '0;
            by_reg           <= '0;
            bw_reg           <= '0;
            bh_reg           <= '0;
            secure_reg       <= 1'b0;
            bad_reg          <= 1'b0;
            stat_code_reg    <= STATUS_FILL;
            right_reg        <= '0;
            left_reg         <= '0;
            xf_reg           <= '0;
            xc_reg           <= '0;
            x0_reg           <= '0;
            y0_reg           <= '0;
            x_cur_reg        <= '0;
            y_cur_reg        <= '0;
            d_reg            <= '0;
            pass_reg         <= 1'b0;
            bar_idx_reg      <= '0;
            len_reg          <= '0;
            ft_reg           <= '0;
            ct_reg           <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= STATUS_FILL;
            rect_x_reg       <= '0;
            rect_y_reg       <= '0;
            rect_w_reg       <= '0;
            rect_h_reg       <= '0;
            rect_color_reg   <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DISPLAY_WIDTH:    disp_w_reg       <= cfg_data[DIM_W-1:0];
                    CFG_DISPLAY_HEIGHT:   disp_h_reg       <= cfg_data[DIM_W-1:0];
                    CFG_FOUNDATION_COLOR: found_color_reg  <= cfg_data;
                    CFG_CHROME_COLOR:     chrome_color_reg <= cfg_data;
                    CFG_SECURE_COLOR:     secure_color_reg <= cfg_data;
                    default:              ;
                endcase
            end

            // load a new result, else drop the old one once taken
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        bx_reg     <= bounds_x[COORD_W-1:0];
                        by_reg     <= bounds_y[COORD_W-1:0];
                        bw_reg     <= bounds_width;
                        bh_reg     <= bounds_height;
                        secure_reg <= (presentation == PRES_SECURE);
                        bad_reg    <= (surface_id == '0) || (frame_seq == '0)
                                   || ((presentation != PRES_CHROME)
                                       && (presentation != PRES_SECURE))
                                   || (bounds_width == '0) || (bounds_height == '0)
                                   || bounds_x[12] || bounds_y[12];
                        state_reg  <= S_CHKX;
                    end
                end
                S_CHKX:
                begin
                    right_reg <= sum;
                    bad_reg   <= bad_reg || !disp_ok || (sum > {1'b0, disp_w_reg});
                    state_reg <= S_CHKY;
                end
                S_CHKY:
                begin
                    len_reg <= len_new;
                    ft_reg  <= (len_new >= FT_THICK_MIN) ? 2'd3
                             : ((len_new >= FT_MID_MIN) ? 2'd2 : 2'd1);
                    ct_reg  <= (len_new >= CT_THICK_MIN) ? 2'd2 : 2'd1;
                    if (theme_bad)
                    begin
                        stat_code_reg <= STATUS_BAD_THEME;
                        state_reg     <= S_STAT;
                    end
                    else if (bad_reg || (sum > {1'b0, disp_h_reg}))
                    begin
                        stat_code_reg <= STATUS_BAD_ENTRY;
                        state_reg     <= S_STAT;
                    end
                    else
                    begin
                        state_reg <= S_LEFT;
                    end
                end
                S_STAT:
                begin
                    if (ld)
                    begin
                        status_reg     <= stat_code_reg;
                        rect_x_reg     <= '0;
                        rect_y_reg     <= '0;
                        rect_w_reg     <= '0;
                        rect_h_reg     <= '0;
                        rect_color_reg <= '0;
                        last_reg       <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_LEFT:
                begin
                    left_reg  <= sum[COORD_W-1:0];
                    state_reg <= S_FTX;
                end
                S_FTX:
                begin
                    xf_reg    <= sum[COORD_W-1:0];
                    state_reg <= S_CTX;
                end
                S_CTX:
                begin
                    xc_reg      <= sum[COORD_W-1:0];
                    bar_idx_reg <= '0;
                    state_reg   <= has_seam ? S_X0 : S_BAR;
                end
                S_X0:
                begin
                    x0_reg    <= sum[COORD_W-1:0];
                    state_reg <= S_SEAMY;
                end
                S_SEAMY:
                begin
                    y0_reg    <= sum[COORD_W-1:0];
                    state_reg <= S_BAR;
                end
                S_BAR:
                begin
                    if (ld)
                    begin
                        status_reg    <= STATUS_FILL;
                        rect_y_reg    <= by_reg;
                        last_reg      <= (bar_idx_reg == 2'd3) && !has_seam;
                        case (bar_idx_reg)
                            2'd0:
                            begin
                                rect_x_reg     <= left_reg;
                                rect_w_reg     <= len_reg;
                                rect_h_reg     <= {3'b000, ft_reg};
                                rect_color_reg <= found_color_reg;
                            end
                            2'd1:
                            begin
                                rect_x_reg     <= xf_reg;
                                rect_w_reg     <= {3'b000, ft_reg};
                                rect_h_reg     <= len_reg;
                                rect_color_reg <= found_color_reg;
                            end
                            2'd2:
                            begin
                                rect_x_reg     <= left_reg;
                                rect_w_reg     <= len_reg;
                                rect_h_reg     <= {3'b000, ct_reg};
                                rect_color_reg <= core_color;
                            end
                            default:
                            begin
                                rect_x_reg     <= xc_reg;
                                rect_w_reg     <= {3'b000, ct_reg};
                                rect_h_reg     <= len_reg;
                                rect_color_reg <= core_color;
                            end
                        endcase
                        bar_idx_reg <= bar_idx_reg + 2'd1;
                        if (bar_idx_reg == 2'd3)
                        begin
                            pass_reg  <= 1'b0;
                            x_cur_reg <= x0_reg;
                            y_cur_reg <= y0_reg;
                            d_reg     <= len_m3[3:0];
                            state_reg <= has_seam ? S_SEAM : S_IDLE;
                        end
                    end
                end
                S_SEAM:
                begin
                    if (ld)
                    begin
                        status_reg     <= STATUS_FILL;
                        rect_x_reg     <= x_cur_reg;
                        rect_y_reg     <= y_cur_reg;
                        rect_w_reg     <= 5'd1;
                        rect_h_reg     <= pass_reg ? 5'd1 : 5'd2;
                        rect_color_reg <= pass_reg ? core_color : found_color_reg;
                        last_reg       <= pass_reg && (d_reg == '0);
                        if (d_reg == '0)
                        begin
                            pass_reg  <= 1'b1;
                            x_cur_reg <= x0_reg;
                            y_cur_reg <= y0_reg;
                            d_reg     <= len_m3[3:0];
                            state_reg <= pass_reg ? S_IDLE : S_SEAM;
                        end
                        else
                        begin
                            // step right; rise one row on every other column
                            x_cur_reg <= x_cur_reg + 12'd1;
                            y_cur_reg <= y_cur_reg - {11'd0, !d_reg[0]};
                            d_reg     <= d_reg - 4'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign rect_x     = rect_x_reg;
    assign rect_y     = rect_y_reg;
    assign rect_w     = rect_w_reg;
    assign rect_h     = rect_h_reg;
    assign rect_color = rect_color_reg;
    assign last       = last_reg;

endmodule

>>> tb/sv/trm_mark_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// trm_mark_checker
// Watches the request and result channels of the trusted mark rasterizer,
// keeps its own copy of the display and theme registers, works out the fill
// rectangles or status result of every accepted overlay entry, and compares
// each accepted result against the oldest one still outstanding.
// ============================================================================
module trm_mark_checker
    import trm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  cfg_idx_t             cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data,

    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [31:0]          surface_id,
    input  logic [1:0]           presentation,
    input  logic signed [12:0]   bounds_x,
    input  logic signed [12:0]   bounds_y,
    input  logic [12:0]          bounds_width,
    input  logic [12:0]          bounds_height,
    input  logic [31:0]          frame_seq,

    input  logic                 out_valid,
    input  logic                 out_stall,
    input  status_t              status,
    input  logic [COORD_W-1:0]   rect_x,
    input  logic [COORD_W-1:0]   rect_y,
    input  side_t                rect_w,
    input  side_t                rect_h,
    input  logic [COLOR_W-1:0]   rect_color,
    input  logic                 last,

    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        status_t              st;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        side_t                w;
        side_t                h;
        logic [COLOR_W-1:0]   color;
        logic                 is_last;
    } rect_cmd_t;

    rect_cmd_t            pending_rects[$];
    logic [DIM_W-1:0]     disp_w;
    logic [DIM_W-1:0]     disp_h;
    logic [COLOR_W-1:0]   fnd_color;
    logic [COLOR_W-1:0]   chr_color;
    logic [COLOR_W-1:0]   sec_color;

    function automatic rect_cmd_t make_rect(status_t st, int x, int y, int w, int h,
                                            logic [COLOR_W-1:0] color);
        rect_cmd_t r;
        r.st      = st;
        r.x       = COORD_W'(x);
        r.y       = COORD_W'(y);
        r.w       = SIDE_W'(w);
        r.h       = SIDE_W'(h);
        r.color   = color;
        r.is_last = 1'b0;
        return r;
    endfunction

    function automatic string describe(rect_cmd_t r);
        return $sformatf("st=%0d x=%0d y=%0d w=%0d h=%0d c=%06h last=%0b",
                         r.st, r.x, r.y, r.w, r.h, r.color, r.is_last);
    endfunction

    function automatic void predict_mark(logic [31:0] sid, logic [1:0] pres,
                                         logic signed [12:0] bx, logic signed [12:0] by,
                                         logic [12:0] bw, logic [12:0] bh,
                                         logic [31:0] seq);
        rect_cmd_t            mark[$];
        int                   dw, dh, right, top, side, left, ft, ct;
        int                   span, thick, row, ht;
        bit                   secure, display_ok;
        logic [COLOR_W-1:0]   core, shade;

        dw = int'(disp_w);
        dh = int'(disp_h);
        display_ok = dw >= 1 && dw <= MAX_DIM && dh >= 1 && dh <= MAX_DIM;

        if (fnd_color == chr_color || fnd_color == sec_color || chr_color == sec_color)
            mark.push_back(make_rect(STATUS_BAD_THEME, 0, 0, 0, 0, '0));
        else if (!display_ok || sid == 0 || pres > PRES_SECURE || bw == 0 || bh == 0 ||
                 seq == 0 || bx < 0 || by < 0 ||
                 int'(bx) + int'(bw) > dw || int'(by) + int'(bh) > dh)
            mark.push_back(make_rect(STATUS_BAD_ENTRY, 0, 0, 0, 0, '0));
        else
        begin
            secure = (pres == PRES_SECURE);
            right  = int'(bx) + int'(bw);
            top    = int'(by);
            side   = (bw < bh) ? int'(bw) : int'(bh);
            if (secure && side > int'(SIDE_SECURE))
                side = int'(SIDE_SECURE);
            if (!secure && side > int'(SIDE_CHROME))
                side = int'(SIDE_CHROME);
            left = right - side;
            ft   = side >= int'(FT_THICK_MIN) ? 3 : (side >= int'(FT_MID_MIN) ? 2 : 1);
            ct   = side >= int'(CT_THICK_MIN) ? 2 : 1;
            core = secure ? sec_color : chr_color;

            mark.push_back(make_rect(STATUS_FILL, left, top, side, ft, fnd_color));
            mark.push_back(make_rect(STATUS_FILL, right - ft, top, ft, side, fnd_color));
            mark.push_back(make_rect(STATUS_FILL, left, top + (ft > ct ? (ft - ct) / 2 : 0),
                                     side, ct, core));
            mark.push_back(make_rect(STATUS_FILL, right - ct, top, ct, side, core));

            if (secure && side >= int'(SEAM_MIN_SIDE))
            begin
                span = side - 2;
                for (int pass = 0; pass < 2; pass++)
                begin
                    thick = (pass == 0) ? 2 : 1;
                    shade = (pass == 0) ? fnd_color : core;
                    for (int s = 0; s < span; s++)
                    begin
                        row = top + ft + (span - 1 - s) / 2;
                        if (row >= dh)
                            continue;
                        ht = (dh - row > thick) ? thick : dh - row;
                        mark.push_back(make_rect(STATUS_FILL, left + 1 + s, row, 1, ht,
                                                 shade));
                    end
                end
            end
        end

        mark[mark.size() - 1].is_last = 1'b1;
        foreach (mark[i])
            pending_rects.push_back(mark[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rect_cmd_t seen;
        rect_cmd_t want;
        if (!rst_n)
        begin
            disp_w      <= RST_DISPLAY_WIDTH;
            disp_h      <= RST_DISPLAY_HEIGHT;
            fnd_color   <= RST_FOUNDATION_COLOR;
            chr_color   <= RST_CHROME_COLOR;
            sec_color   <= RST_SECURE_COLOR;
            pending_rects.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DISPLAY_WIDTH:    disp_w    <= cfg_data[DIM_W-1:0];
                    CFG_DISPLAY_HEIGHT:   disp_h    <= cfg_data[DIM_W-1:0];
                    CFG_FOUNDATION_COLOR: fnd_color <= cfg_data;
                    CFG_CHROME_COLOR:     chr_color <= cfg_data;
                    CFG_SECURE_COLOR:     sec_color <= cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                predict_mark(surface_id, presentation, bounds_x, bounds_y,
                             bounds_width, bounds_height, frame_seq);

            if (out_valid && !out_stall)
            begin
                seen = {status, rect_x, rect_y, rect_w, rect_h, rect_color, last};
                if (pending_rects.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result %s", $time, describe(seen));
                end
                else
                begin
                    want = pending_rects.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                                     $time, describe(want), describe(seen));
                    end
                end
            end

            outstanding <= pending_rects.size();
        end
    end

endmodule

>>> tb/sv/tb_trusted_mark_rect_rasterizer.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_trusted_mark_rect_rasterizer
// Drives overlay entries into the trusted mark rasterizer under several
// display sizes and themes: a directed set of corner cases, then random
// entries, mostly well formed. Both channels idle at random, and one long
// result hold-off backs the block up. The checker instance judges results.
// ============================================================================
module tb_trusted_mark_rect_rasterizer
    import trm_pkg::*;
();

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;

    localparam logic [1:0] PRES_BAD_LO = 2'd2;
    localparam logic [1:0] PRES_BAD_HI = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    cfg_idx_t             cfg_index;
    logic [COLOR_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [31:0]          surface_id;
    logic [1:0]           presentation;
    logic signed [12:0]   bounds_x;
    logic signed [12:0]   bounds_y;
    logic [12:0]          bounds_width;
    logic [12:0]          bounds_height;
    logic [31:0]          frame_seq;
    logic                 out_valid;
    logic                 out_stall;
    status_t              status;
    logic [COORD_W-1:0]   rect_x;
    logic [COORD_W-1:0]   rect_y;
    side_t                rect_w;
    side_t                rect_h;
    logic [COLOR_W-1:0]   rect_color;
    logic                 last;

    int                   mismatches;
    int                   outstanding;
    bit                   tx_noise = 1'b1;
    bit                   rx_noise = 1'b1;
    int                   holds_asked = 0;
    int                   cur_w = 1920;
    int                   cur_h = 1080;

    trusted_mark_rect_rasterizer dut (.*);

    trm_mark_checker mark_check (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_trusted_mark_rect_rasterizer: errors");
        $finish;
    end

    initial
    begin : receiver
        int holds_done;
        holds_done = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= rx_noise && ($urandom_range(0, 99) < 18);
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [COLOR_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic set_display(int w, int h, logic [COLOR_W-1:0] f,
                               logic [COLOR_W-1:0] c, logic [COLOR_W-1:0] s);
        write_reg(CFG_DISPLAY_WIDTH, COLOR_W'(w));
        write_reg(CFG_DISPLAY_HEIGHT, COLOR_W'(h));
        write_reg(CFG_FOUNDATION_COLOR, f);
        write_reg(CFG_CHROME_COLOR, c);
        write_reg(CFG_SECURE_COLOR, s);
        cfg_we <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    task automatic pick_theme(output logic [COLOR_W-1:0] f, output logic [COLOR_W-1:0] c,
                              output logic [COLOR_W-1:0] s);
        do
        begin
            f = COLOR_W'($urandom);
            c = COLOR_W'($urandom);
            s = COLOR_W'($urandom);
        end
        while (f == c || f == s || c == s);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_entry(logic [31:0] sid, logic [1:0] pres,
                              logic signed [12:0] bx, logic signed [12:0] by,
                              logic [12:0] bw, logic [12:0] bh, logic [31:0] seq);
        if (tx_noise && $urandom_range(0, 99) < 18)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        surface_id    <= sid;
        presentation  <= pres;
        bounds_x      <= bx;
        bounds_y      <= by;
        bounds_width  <= bw;
        bounds_height <= bh;
        frame_seq     <= seq;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random();
        int                  pick, span_w, span_h, w, h, x, y;
        logic [31:0]         sid, seq;
        logic [1:0]          pres;
        logic signed [12:0]  bx, by;
        logic [12:0]         bw, bh;

        span_w = (cur_w >= 1 && cur_w <= MAX_DIM_DEFAULT) ? cur_w : 1920;
        span_h = (cur_h >= 1 && cur_h <= MAX_DIM_DEFAULT) ? cur_h : 1080;
        sid  = $urandom;
        seq  = $urandom;
        if (sid == 0)
            sid = 1;
        if (seq == 0)
            seq = 1;
        pres = $urandom_range(0, 1) ? PRES_SECURE : PRES_CHROME;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, span_w)
                                        : $urandom_range(1, span_w < 24 ? span_w : 24);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, span_h)
                                        : $urandom_range(1, span_h < 24 ? span_h : 24);
        x = ($urandom_range(0, 3) == 0) ? span_w - w : $urandom_range(0, span_w - w);
        y = ($urandom_range(0, 3) == 0) ? span_h - h : $urandom_range(0, span_h - h);
        bx = 13'(x);
        by = 13'(y);
        bw = 13'(w);
        bh = 13'(h);

        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            sid  = $urandom;
            seq  = $urandom;
            pres = 2'($urandom);
            bx   = 13'($urandom);
            by   = 13'($urandom);
            bw   = 13'($urandom);
            bh   = 13'($urandom);
        end
        else if (pick < 22)
        begin
            case ($urandom_range(0, 8))
                0: sid = '0;
                1: pres = $urandom_range(0, 1) ? PRES_BAD_LO : PRES_BAD_HI;
                2: bw = '0;
                3: bh = '0;
                4: seq = '0;
                5: bx = 13'($urandom_range(4096, 8191));
                6: by = 13'($urandom_range(4096, 8191));
                7: bx = 13'(span_w - w + int'($urandom_range(1, 8)));
                default: by = 13'(span_h - h + int'($urandom_range(1, 8)));
            endcase
        end
        send_entry(sid, pres, bx, by, bw, bh, seq);
    endtask

    initial
    begin : stimulus
        int                   sides[8] = '{1, 2, 3, 4, 5, 7, 9, 10};
        logic [COLOR_W-1:0]   fc, cc, sc;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_DISPLAY_WIDTH;
        cfg_data      = '0;
        in_valid      = 1'b0;
        surface_id    = '0;
        presentation  = PRES_CHROME;
        bounds_x      = '0;
        bounds_y      = '0;
        bounds_width  = '0;
        bounds_height = '0;
        frame_seq     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_entry(32'h1, PRES_CHROME, 0, 0, 14, 14, 32'h1);
        send_entry(32'hFFFF_FFFF, PRES_SECURE, 1902, 0, 18, 18, 32'hFFFF_FFFF);
        send_entry(32'h55, PRES_SECURE, 1820, 1030, 100, 50, 32'h77);
        foreach (sides[i])
            send_entry(32'h100 + i, PRES_SECURE, 40, 40, 13'(sides[i]), 20, 32'h9);
        send_entry(32'h200, PRES_CHROME, 1914, 1074, 6, 6, 32'h3);
        send_entry(32'h0, PRES_CHROME, 0, 0, 14, 14, 32'h1);
        send_entry(32'h1, PRES_BAD_LO, 0, 0, 14, 14, 32'h1);
        send_entry(32'h1, PRES_BAD_HI, 0, 0, 14, 14, 32'h1);
        send_entry(32'h1, PRES_SECURE, 0, 0, 0, 14, 32'h1);
        send_entry(32'h1, PRES_SECURE, 0, 0, 14, 0, 32'h1);
        send_entry(32'h1, PRES_SECURE, 0, 0, 14, 14, 32'h0);
        send_entry(32'h1, PRES_CHROME, -1, 0, 14, 14, 32'h1);
        send_entry(32'h1, PRES_CHROME, 0, -4096, 14, 14, 32'h1);
        send_entry(32'h1, PRES_SECURE, 1901, 0, 20, 20, 32'h1);
        send_entry(32'h1, PRES_SECURE, 0, 1061, 20, 20, 32'h1);

        drain();
        set_display(4096, 4096, 24'h000000, 24'hFFFFFF, 24'h00FF00);
        repeat (60) send_random();

        drain();
        pick_theme(fc, cc, sc);
        set_display(1, 1, fc, cc, sc);
        repeat (25) send_random();

        // quiet stretch: neither side idles
        drain();
        pick_theme(fc, cc, sc);
        set_display($urandom_range(16, 96), $urandom_range(16, 96), fc, cc, sc);
        tx_noise = 1'b0;
        rx_noise <= 1'b0;
        repeat (80) send_random();
        tx_noise = 1'b1;
        rx_noise <= 1'b1;

        drain();
        set_display(0, 1080, fc, cc, sc);
        repeat (15) send_random();

        drain();
        set_display(8191, 4097, fc, cc, sc);
        repeat (10) send_random();

        drain();
        set_display(1920, 1080, 24'h123456, 24'h123456, 24'h00FF00);
        repeat (7) send_random();
        drain();
        set_display(1920, 1080, 24'h000000, 24'hABCDEF, 24'hABCDEF);
        repeat (7) send_random();
        drain();
        set_display(1920, 1080, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        repeat (6) send_random();

        // long result hold-off while requests keep coming
        drain();
        pick_theme(fc, cc, sc);
        set_display(1920, 1080, fc, cc, sc);
        holds_asked <= holds_asked + 1;
        repeat (80) send_random();

        drain();
        pick_theme(fc, cc, sc);
        set_display(640, 480, fc, cc, sc);
        repeat (50) send_random();

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("tb_trusted_mark_rect_rasterizer: clean");
        else
            $display("tb_trusted_mark_rect_rasterizer: errors");
        $finish;
    end

endmodule
